// ===== src/cle_pkg.sv =====
// ----------------------------------------------------------------------------
// cle_pkg
// shared types and constants of the console line editor
// ----------------------------------------------------------------------------
package cle_pkg;

    localparam int DEFAULT_MAX_LINE = 256;
    localparam int CAP_W            = 9;
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;
    localparam int QUEUE_DEPTH      = 4;
    localparam int OUT_DATA_W       = 40;

    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_DEL = 8'd127;
    localparam logic [7:0] CH_ESC = 8'd27;
    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_SP  = 8'd32;
    localparam logic [7:0] CH_NL  = 8'd10;

    typedef enum logic {
        K_PUT,
        K_ERASE
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [7:0]  index;
        logic        done;
        logic [8:0]  length;
    } t_cmd;

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_SPACE,
        PH_TAIL
    } t_phase;

endpackage

// ===== src/console_line_editor.sv =====
// ----------------------------------------------------------------------------
// console_line_editor
// canonical-mode line editor: received bytes in, buffer writes, echo and
// line completion out
// ----------------------------------------------------------------------------
// The front takes one received byte every cycle while the four-entry request
// queue has room, and keeps the line position and the escape state. The back
// turns each request into result items at one per cycle while the output is
// not stalled, from a registered output: a stored byte or carriage return gives
// one item, an erase three, and a new request is taken only after the last
// item of the one before. A result passes through the request queue and the
// back's output register after its byte is accepted. No clearing pass is
// needed after reset. The capacity register is written on the cfg channel,
// which is always ready, and should be changed only while the block is idle.
// ----------------------------------------------------------------------------
module console_line_editor #(
    parameter int MAX_LINE = cle_pkg::DEFAULT_MAX_LINE
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // rx_byte
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // echo_valid, echo_byte, store_valid, store_index, store_byte,
    // line_done, line_length, zero pad
    output logic [cle_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tlast,  // last
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cle_pkg::CAP_W-1:0]       i_cfg_data     // line_capacity
);

    logic [cle_pkg::CAP_W-1:0] r_capacity;
    cle_pkg::t_cmd             push_cmd, head_cmd;
    logic                      push, pop, full, empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= cle_pkg::CAP_RESET;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
        end
    end

    cle_front #(
        .MAX_LINE(MAX_LINE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_byte       (s_axis_tdata),
        .i_capacity   (r_capacity),
        .i_queue_full (full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    cle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    cle_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (head_cmd),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

// ===== src/cle_front.sv =====
// ----------------------------------------------------------------------------
// cle_front
// accepts received bytes, tracks position and escape, issues editor requests
// ----------------------------------------------------------------------------
module cle_front #(
    parameter int MAX_LINE = cle_pkg::DEFAULT_MAX_LINE
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [7:0]               i_byte,
    input  logic [cle_pkg::CAP_W-1:0] i_capacity,
    input  logic                     i_queue_full,
    output logic                     o_push,
    output cle_pkg::t_cmd            o_cmd
);

    localparam int PW = $clog2(MAX_LINE);
    localparam int W  = (PW + 1 > cle_pkg::CAP_W) ? PW + 1 : cle_pkg::CAP_W;
    localparam logic [W-1:0] MaxW = W'(MAX_LINE);

    logic [PW-1:0] r_pos, n_pos;
    logic          r_skip, n_skip;
    logic          accept;
    logic [W-1:0]  cap_ext, eff_cap, pos_ext, next_ext;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;

    assign cap_ext  = W'(i_capacity);
    assign pos_ext  = W'(r_pos);
    assign next_ext = pos_ext + W'(1);

    always_comb begin
        if (cap_ext == '0) begin
            eff_cap = W'(1);
        end else if (cap_ext > MaxW) begin
            eff_cap = MaxW;
        end else begin
            eff_cap = cap_ext;
        end
    end

    always_comb begin
        n_pos        = r_pos;
        n_skip       = r_skip;
        o_push       = 1'b0;
        o_cmd.kind   = cle_pkg::K_PUT;
        o_cmd.data   = i_byte;
        o_cmd.index  = pos_ext[7:0];
        o_cmd.done   = 1'b0;
        o_cmd.length = '0;
        if (accept) begin
            priority if (r_skip) begin
                n_skip = 1'b0;
            end else if (i_byte == cle_pkg::CH_ESC) begin
                n_skip = 1'b1;
            end else if (i_byte == cle_pkg::CH_CR) begin
                o_push       = 1'b1;
                o_cmd.data   = cle_pkg::CH_NL;
                o_cmd.done   = 1'b1;
                o_cmd.length = next_ext[8:0];
                n_pos        = '0;
            end else if (i_byte == cle_pkg::CH_DEL) begin
                if (r_pos != '0) begin
                    o_push     = 1'b1;
                    o_cmd.kind = cle_pkg::K_ERASE;
                    n_pos      = r_pos - PW'(1);
                end
            end else begin
                o_push = 1'b1;
                if (next_ext >= eff_cap) begin
                    o_cmd.done   = 1'b1;
                    o_cmd.length = next_ext[8:0];
                    n_pos        = '0;
                end else begin
                    n_pos = next_ext[PW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_skip <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_skip <= n_skip;
        end
    end

endmodule

// ===== src/cle_queue.sv =====
// ----------------------------------------------------------------------------
// cle_queue
// short request queue between front and back
// ----------------------------------------------------------------------------
module cle_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cle_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output cle_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);

    localparam int AW = $clog2(cle_pkg::QUEUE_DEPTH);

    cle_pkg::t_cmd r_mem [cle_pkg::QUEUE_DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_count;

    assign o_full  = r_count == (AW + 1)'(cle_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            r_count <= r_count + (AW + 1)'(i_push) - (AW + 1)'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty queue");

endmodule

// ===== src/cle_back.sv =====
// ----------------------------------------------------------------------------
// cle_back
// expands queued requests into result items behind an output register
// ----------------------------------------------------------------------------
module cle_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cle_pkg::t_cmd                   i_cmd,
    input  logic                            i_empty,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [cle_pkg::OUT_DATA_W-1:0]  o_data,
    output logic                            o_last
);

    cle_pkg::t_phase r_state, n_state;
    logic            r_valid, n_valid;
    logic            r_last, n_last;
    logic [cle_pkg::OUT_DATA_W-1:0] r_data, n_data;
    logic            free;

    assign free    = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;

    function automatic logic [cle_pkg::OUT_DATA_W-1:0] pack_echo(input logic [7:0] ch);
        pack_echo = {4'd0, 9'd0, 1'b0, 8'd0, 8'd0, 1'b0, ch, 1'b1};
    endfunction

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        n_data  = r_data;
        n_last  = r_last;
        o_pop   = 1'b0;
        if (free) begin
            unique case (r_state)
                cle_pkg::PH_SPACE: begin
                    n_valid = 1'b1;
                    n_data  = pack_echo(cle_pkg::CH_SP);
                    n_last  = 1'b0;
                    n_state = cle_pkg::PH_TAIL;
                end
                cle_pkg::PH_TAIL: begin
                    n_valid = 1'b1;
                    n_data  = pack_echo(cle_pkg::CH_BS);
                    n_last  = 1'b1;
                    n_state = cle_pkg::PH_HEAD;
                end
                cle_pkg::PH_HEAD: begin
                    if (!i_empty) begin
                        o_pop   = 1'b1;
                        n_valid = 1'b1;
                        if (i_cmd.kind == cle_pkg::K_ERASE) begin
                            n_data  = pack_echo(cle_pkg::CH_BS);
                            n_last  = 1'b0;
                            n_state = cle_pkg::PH_SPACE;
                        end else begin
                            n_data = {4'd0, i_cmd.length, i_cmd.done, i_cmd.data,
                                      i_cmd.index, 1'b1, i_cmd.data, 1'b1};
                            n_last = 1'b1;
                        end
                    end else begin
                        n_valid = 1'b0;
                    end
                end
                default: begin
                    n_state = cle_pkg::PH_HEAD;
                    n_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cle_pkg::PH_HEAD;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_last <= n_last;
    end

    a_erase_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != cle_pkg::PH_HEAD) |-> r_valid)
        else $error("erase sequence without a pending result");

    a_pop_in_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == cle_pkg::PH_HEAD))
        else $error("request taken during erase sequence");

    a_erase_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != cle_pkg::PH_HEAD) |-> !r_last)
        else $error("erase sequence marked last too early");

endmodule
